// ===== src/fpasmd_pkg.sv =====
// Package for the binary16/binary32 add, subtract, multiply and divide unit.
// Holds operation and rounding codes, register indexes and datapath widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fpasmd_pkg;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        RM_RTZ = 2'd0,
        RM_RNE = 2'd1,
        RM_RUP = 2'd2,
        RM_RDN = 2'd3
    } rmode_t;

    localparam logic CFG_PRECISION = 1'b0;
    localparam logic CFG_ROUNDING  = 1'b1;

    localparam int OP_W      = 2;
    localparam int WORD_W    = 32;
    localparam int CFG_W     = 2;
    localparam int MAN_W     = 24;
    localparam int ALN_W     = 27;
    localparam int SUM_W     = 28;
    localparam int SIG_W     = 48;
    localparam int EXP_W     = 12;
    localparam int REM_W     = 26;
    localparam int QUO_W     = 27;
    localparam int CNT_W     = 5;
    localparam int DIV_STEPS = 27;

endpackage

`default_nettype wire

// ===== src/fpasmd_if.sv =====
// Valid/ready channel interfaces for request and result transactions.
// Depends on fpasmd_pkg for the payload widths.
`timescale 1ns / 1ps
`default_nettype none

interface fpasmd_req_if;
    logic                            valid;
    logic                            ready;
    logic [fpasmd_pkg::OP_W-1:0]     req_type;
    logic [fpasmd_pkg::WORD_W-1:0]   operand_a;
    logic [fpasmd_pkg::WORD_W-1:0]   operand_b;

    modport source (output valid, output req_type, output operand_a, output operand_b,
                    input ready);
    modport sink   (input valid, input req_type, input operand_a, input operand_b,
                    output ready);
endinterface

interface fpasmd_res_if;
    logic                            valid;
    logic                            ready;
    logic [fpasmd_pkg::WORD_W-1:0]   result_bits;

    modport source (output valid, output result_bits, input ready);
    modport sink   (input valid, input result_bits, output ready);
endinterface

`default_nettype wire

// ===== src/fp_add_sub_mul_div.sv =====
// NaN, infinity or mul/div zero operands give their result from decode, a zero sum from the add step;
// other results are normalised, shifted for subnormals and rounded. Divide first pre-normalises (up to 46
// shifts), then takes 27 restoring division steps, then normalise, subnormal shift and round.
// Throughput: one transaction at a time; the next request is taken after the result
// transaction completes. Normalisation shifts by 8 or 1 bits per cycle.
// Reset: binary32, round toward zero, idle with no result pending. Depends on fpasmd_pkg, fpasmd_if.
`timescale 1ns / 1ps
`default_nettype none

module fp_add_sub_mul_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    fpasmd_req_if.sink                         req,
    fpasmd_res_if.source                       res,
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_index,
    input  wire logic [fpasmd_pkg::CFG_W-1:0]  cfg_wdata
);

    typedef enum logic [3:0] {
        S_IDLE, S_DEC, S_ADD, S_MUL, S_DNRM, S_DIV, S_NORM, S_DENORM, S_ROUND, S_OUT
    } state_t;

    localparam int EW = fpasmd_pkg::EXP_W;

    state_t                              state_reg;
    logic                                prec_reg;
    fpasmd_pkg::rmode_t                  rmode_reg;
    fpasmd_pkg::op_t                     op_reg;
    logic [fpasmd_pkg::WORD_W-1:0]       a_reg, b_reg, res_reg;
    logic [fpasmd_pkg::MAN_W-1:0]        ma_reg, mb_reg;
    logic signed [EW-1:0]                xa_reg, xb_reg, e_reg;
    logic                                sa_reg, sb_reg, sign_reg, sticky_reg;
    logic [fpasmd_pkg::SIG_W-1:0]        sig_reg;
    logic [fpasmd_pkg::REM_W-1:0]        rem_reg;
    logic [fpasmd_pkg::QUO_W-1:0]        quo_reg;
    logic [fpasmd_pkg::CNT_W-1:0]        cnt_reg;

    // format constants
    logic [7:0]                          emax;
    logic signed [EW-1:0]                bias_s, f_s;
    logic [fpasmd_pkg::MAN_W-1:0]        hid;
    logic [fpasmd_pkg::WORD_W-1:0]       qnan;

    always_comb
    begin
        emax   = prec_reg ? 8'hFF : 8'h1F;
        bias_s = prec_reg ? EW'(127) : EW'(15);
        f_s    = prec_reg ? EW'(23) : EW'(10);
        hid    = prec_reg ? 24'h800000 : 24'h000400;
        qnan   = prec_reg ? 32'h7FC00000 : 32'h00007E00;
    end

    function automatic logic [31:0] enc(input logic p, input logic s, input logic [7:0] e,
                                        input logic [23:0] fr);
        logic [31:0] r;
        r = p ? {s, e, fr[22:0]} : {16'h0000, s, e[4:0], fr[9:0]};
        return r;
    endfunction

    // operand decode
    logic                  sa, sb, sbe, nan_a, nan_b, ia, ib, za, zb;
    logic [7:0]            ea, eb;
    logic [22:0]           fa, fb;
    logic [23:0]           ma, mb;
    logic signed [EW-1:0]  xa, xb;
    logic                  special;
    logic [31:0]           special_val;

    always_comb
    begin
        if (prec_reg)
        begin
            sa = a_reg[31]; ea = a_reg[30:23]; fa = a_reg[22:0];
            sb = b_reg[31]; eb = b_reg[30:23]; fb = b_reg[22:0];
        end
        else
        begin
            sa = a_reg[15]; ea = {3'b000, a_reg[14:10]}; fa = {13'h0, a_reg[9:0]};
            sb = b_reg[15]; eb = {3'b000, b_reg[14:10]}; fb = {13'h0, b_reg[9:0]};
        end
        ma = (ea != 8'h00) ? ({1'b0, fa} | hid) : {1'b0, fa};
        mb = (eb != 8'h00) ? ({1'b0, fb} | hid) : {1'b0, fb};
        xa = $signed({4'b0000, ((ea != 8'h00) ? ea : 8'h01)}) - bias_s - f_s;
        xb = $signed({4'b0000, ((eb != 8'h00) ? eb : 8'h01)}) - bias_s - f_s;
        nan_a = (ea == emax) && (fa != 23'h0);
        nan_b = (eb == emax) && (fb != 23'h0);
        ia = (ea == emax);
        ib = (eb == emax);
        za = !ia && (ma == 24'h0);
        zb = !ib && (mb == 24'h0);
        sbe = sb ^ (op_reg == fpasmd_pkg::OP_SUB);
        special = 1'b1;
        special_val = qnan;
        case (op_reg)
            fpasmd_pkg::OP_ADD, fpasmd_pkg::OP_SUB:
            begin
                if (nan_a || nan_b)
                    special_val = qnan;
                else if (ia && ib)
                    special_val = (sa == sbe) ? enc(prec_reg, sa, emax, 24'h0) : qnan;
                else if (ia)
                    special_val = enc(prec_reg, sa, emax, 24'h0);
                else if (ib)
                    special_val = enc(prec_reg, sbe, emax, 24'h0);
                else
                    special = 1'b0;
            end
            fpasmd_pkg::OP_MUL:
            begin
                if (nan_a || nan_b || (ia && zb) || (za && ib))
                    special_val = qnan;
                else if (ia || ib)
                    special_val = enc(prec_reg, sa ^ sb, emax, 24'h0);
                else if (za || zb)
                    special_val = enc(prec_reg, sa ^ sb, 8'h00, 24'h0);
                else
                    special = 1'b0;
            end
            default:
            begin
                if (nan_a || nan_b || (za && zb) || (ia && ib))
                    special_val = qnan;
                else if (ia || zb)
                    special_val = enc(prec_reg, sa ^ sb, emax, 24'h0);
                else if (za || ib)
                    special_val = enc(prec_reg, sa ^ sb, 8'h00, 24'h0);
                else
                    special = 1'b0;
            end
        endcase
    end

    // alignment and add
    logic                   swap, sx, sy, add_sign;
    logic [23:0]            mx, my;
    logic signed [EW-1:0]   xx, dd;
    logic [26:0]            big, small0, sh, sm;
    logic [27:0]            sum;

    always_comb
    begin
        swap = xa_reg < xb_reg;
        mx   = swap ? mb_reg : ma_reg;
        my   = swap ? ma_reg : mb_reg;
        xx   = swap ? xb_reg : xa_reg;
        sx   = swap ? sb_reg : sa_reg;
        sy   = swap ? sa_reg : sb_reg;
        dd   = xx - (swap ? xa_reg : xb_reg);
        big    = {mx, 3'b000};
        small0 = {my, 3'b000};
        sh     = 27'h0;
        if (dd >= EW'(27))
            sm = {26'h0, (small0 != 27'h0)};
        else
        begin
            sh = small0 >> dd[4:0];
            sm = sh | {26'h0, ((sh << dd[4:0]) != small0)};
        end
        if (sx == sy)
        begin
            sum = {1'b0, big} + {1'b0, sm};
            add_sign = sx;
        end
        else if (big >= sm)
        begin
            sum = {1'b0, big - sm};
            add_sign = sx;
        end
        else
        begin
            sum = {1'b0, sm - big};
            add_sign = sy;
        end
    end

    // division step
    logic                   ge;
    logic [25:0]            rem_d;
    logic [26:0]            quo_n;

    always_comb
    begin
        ge    = rem_reg >= {2'b00, mb_reg};
        rem_d = ge ? (rem_reg - {2'b00, mb_reg}) : rem_reg;
        quo_n = {quo_reg[25:0], ge};
    end

    // subnormal shift amount
    logic signed [EW-1:0]   kk;
    assign kk = EW'(1) - bias_s - EW'(47) - e_reg;

    // rounding
    logic [23:0]            q;
    logic [24:0]            q1, q2;
    logic                   half, st, inc, q_ovf, is_sub, to_inf;
    logic signed [EW-1:0]   biased;
    logic [31:0]            round_val;

    always_comb
    begin
        q    = prec_reg ? sig_reg[47:24] : {13'h0, sig_reg[47:37]};
        half = prec_reg ? sig_reg[23] : sig_reg[36];
        st   = sticky_reg | (prec_reg ? (sig_reg[22:0] != 23'h0) : (sig_reg[35:0] != 36'h0));
        case (rmode_reg)
            fpasmd_pkg::RM_RNE: inc = half && (st || q[0]);
            fpasmd_pkg::RM_RUP: inc = !sign_reg && (half || st);
            fpasmd_pkg::RM_RDN: inc = sign_reg && (half || st);
            default:            inc = 1'b0;
        endcase
        q1     = {1'b0, q} + {24'h0, inc};
        q_ovf  = prec_reg ? q1[24] : q1[11];
        q2     = q_ovf ? (q1 >> 1) : q1;
        biased = e_reg + EW'(47) + bias_s + (q_ovf ? EW'(1) : EW'(0));
        is_sub = prec_reg ? !q2[23] : !q2[10];
        to_inf = (rmode_reg == fpasmd_pkg::RM_RNE) ||
                 ((rmode_reg == fpasmd_pkg::RM_RUP) && !sign_reg) ||
                 ((rmode_reg == fpasmd_pkg::RM_RDN) && sign_reg);
        if (is_sub)
            round_val = enc(prec_reg, sign_reg, 8'h00, q2[23:0]);
        else if (biased >= $signed({4'b0000, emax}))
            round_val = to_inf ? enc(prec_reg, sign_reg, emax, 24'h0)
                               : enc(prec_reg, sign_reg, emax - 8'h01, 24'hFFFFFF);
        else
            round_val = enc(prec_reg, sign_reg, biased[7:0], q2[23:0]);
    end

    assign req.ready       = (state_reg == S_IDLE);
    assign res.valid       = (state_reg == S_OUT);
    assign res.result_bits = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            prec_reg  <= 1'b1;
            rmode_reg <= fpasmd_pkg::RM_RTZ;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    fpasmd_pkg::CFG_PRECISION: prec_reg  <= cfg_wdata[0];
                    fpasmd_pkg::CFG_ROUNDING:  rmode_reg <= fpasmd_pkg::rmode_t'(cfg_wdata);
                    default:                   prec_reg  <= prec_reg;
                endcase
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        op_reg    <= fpasmd_pkg::op_t'(req.req_type);
                        a_reg     <= req.operand_a;
                        b_reg     <= req.operand_b;
                        state_reg <= S_DEC;
                    end
                end
                S_DEC:
                begin
                    ma_reg     <= ma;
                    mb_reg     <= mb;
                    xa_reg     <= xa;
                    xb_reg     <= xb;
                    sa_reg     <= sa;
                    sb_reg     <= sbe;
                    sign_reg   <= sa ^ sb;
                    sticky_reg <= 1'b0;
                    if (special)
                    begin
                        res_reg   <= special_val;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        case (op_reg)
                            fpasmd_pkg::OP_ADD, fpasmd_pkg::OP_SUB: state_reg <= S_ADD;
                            fpasmd_pkg::OP_MUL:                     state_reg <= S_MUL;
                            default:                                state_reg <= S_DNRM;
                        endcase
                    end
                end
                S_ADD:
                begin
                    if (sum == 28'h0)
                    begin
                        res_reg   <= enc(prec_reg,
                                         (sx == sy) ? sx : (rmode_reg == fpasmd_pkg::RM_RDN),
                                         8'h00, 24'h0);
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        sig_reg   <= {20'h0, sum};
                        e_reg     <= xx - EW'(3);
                        sign_reg  <= add_sign;
                        state_reg <= S_NORM;
                    end
                end
                S_MUL:
                begin
                    sig_reg   <= ma_reg * mb_reg;
                    e_reg     <= xa_reg + xb_reg;
                    state_reg <= S_NORM;
                end
                S_DNRM:
                begin
                    if ((ma_reg & hid) == 24'h0)
                    begin
                        ma_reg <= ma_reg << 1;
                        xa_reg <= xa_reg - EW'(1);
                    end
                    else if ((mb_reg & hid) == 24'h0)
                    begin
                        mb_reg <= mb_reg << 1;
                        xb_reg <= xb_reg - EW'(1);
                    end
                    else
                    begin
                        rem_reg   <= {2'b00, ma_reg};
                        quo_reg   <= 27'h0;
                        cnt_reg   <= 5'd0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    rem_reg <= rem_d << 1;
                    quo_reg <= quo_n;
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'(fpasmd_pkg::DIV_STEPS - 1))
                    begin
                        sig_reg    <= {21'h0, quo_n};
                        sticky_reg <= (rem_d != 26'h0);
                        e_reg      <= xa_reg - xb_reg - EW'(26);
                        state_reg  <= S_NORM;
                    end
                end
                S_NORM:
                begin
                    if (sig_reg[47:40] == 8'h00)
                    begin
                        sig_reg <= sig_reg << 8;
                        e_reg   <= e_reg - EW'(8);
                    end
                    else if (!sig_reg[47])
                    begin
                        sig_reg <= sig_reg << 1;
                        e_reg   <= e_reg - EW'(1);
                    end
                    else
                        state_reg <= S_DENORM;
                end
                S_DENORM:
                begin
                    if (kk <= EW'(0))
                        state_reg <= S_ROUND;
                    else if (kk > EW'(50))
                    begin
                        sticky_reg <= sticky_reg | (sig_reg != 48'h0);
                        sig_reg    <= 48'h0;
                        e_reg      <= EW'(1) - bias_s - EW'(47);
                        state_reg  <= S_ROUND;
                    end
                    else if (kk >= EW'(8))
                    begin
                        sticky_reg <= sticky_reg | (sig_reg[7:0] != 8'h00);
                        sig_reg    <= sig_reg >> 8;
                        e_reg      <= e_reg + EW'(8);
                    end
                    else
                    begin
                        sticky_reg <= sticky_reg | sig_reg[0];
                        sig_reg    <= sig_reg >> 1;
                        e_reg      <= e_reg + EW'(1);
                    end
                end
                S_ROUND:
                begin
                    res_reg   <= round_val;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (res.ready)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the binary16/binary32 add, subtract, multiply and divide unit.
// Directed table then random transactions per precision and rounding setting.
// Random idling in all phases but one. Depends on fpasmd_pkg, fpasmd_if and fp_add_sub_mul_div.
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
    import fpasmd_pkg::*;

    localparam int RANDOM_PER_PHASE = 160;
    localparam int CYCLE_LIMIT      = 2000000;
    localparam int SETTLE_CYCLES    = 120;

    typedef struct {
        op_t         op;
        logic [31:0] a;
        logic [31:0] b;
        bit          known;
        logic [31:0] want;
    } vector_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_index;
    logic [CFG_W-1:0] cfg_wdata;

    fpasmd_req_if req_ch ();
    fpasmd_res_if res_ch ();

    fp_add_sub_mul_div DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    bit          binary32_sel;
    rmode_t      round_sel;
    bit          calm;
    int          errors;
    int          cycles;
    logic [31:0] expected_results[$];

    vector_t directed[19] = '{
        '{OP_ADD, 32'h3F800000, 32'h3F800000, 1'b1, 32'h40000000},
        '{OP_ADD, 32'h7FC12345, 32'h3F800000, 1'b1, 32'h7FC00000},
        '{OP_SUB, 32'h7F800000, 32'h7F800000, 1'b1, 32'h7FC00000},
        '{OP_MUL, 32'h00000000, 32'h7F800000, 1'b1, 32'h7FC00000},
        '{OP_DIV, 32'h00000000, 32'h80000000, 1'b1, 32'h7FC00000},
        '{OP_DIV, 32'h7F800000, 32'hFF800000, 1'b1, 32'h7FC00000},
        '{OP_DIV, 32'h3F800000, 32'h00000000, 1'b1, 32'h7F800000},
        '{OP_DIV, 32'hBF800000, 32'h00000000, 1'b1, 32'hFF800000},
        '{OP_ADD, 32'h3F800000, 32'hBF800000, 1'b1, 32'h00000000},
        '{OP_ADD, 32'h80000000, 32'h80000000, 1'b1, 32'h80000000},
        '{OP_MUL, 32'h7F7FFFFF, 32'h40000000, 1'b1, 32'h7F7FFFFF},
        '{OP_MUL, 32'h00000001, 32'h3F000000, 1'b1, 32'h00000000},
        '{OP_ADD, 32'hFFFFFFFF, 32'h00000000, 1'b1, 32'h7FC00000},
        '{OP_SUB, 32'h7F7FFFFF, 32'hFF7FFFFF, 1'b0, 32'h0},
        '{OP_DIV, 32'h3F800000, 32'h40400000, 1'b0, 32'h0},
        '{OP_MUL, 32'h00800000, 32'h3F000000, 1'b0, 32'h0},
        '{OP_ADD, 32'h00000001, 32'h80000000, 1'b0, 32'h0},
        '{OP_SUB, 32'h3F800001, 32'h3F800000, 1'b0, 32'h0},
        '{OP_DIV, 32'h00000001, 32'h7F7FFFFF, 1'b0, 32'h0}
    };

    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [31:0] fp_encode(bit hf, bit s, int e, logic [31:0] frac);
        int fb;
        int eb;
        fb = hf ? 10 : 23;
        eb = hf ? 5 : 8;
        return (32'(s) << (fb + eb)) | (32'(e) << fb) | frac;
    endfunction

    function automatic logic [31:0] fp_qnan(bit hf);
        return hf ? 32'h00007E00 : 32'h7FC00000;
    endfunction

    function automatic void fp_unpack(input bit hf, input logic [31:0] bits, output bit s,
                                      output int ef, output logic [31:0] fr,
                                      output logic [63:0] m, output int x);
        int fb;
        int eb;
        int bias;
        int emax;
        logic [31:0] mask;
        fb   = hf ? 10 : 23;
        eb   = hf ? 5 : 8;
        bias = hf ? 15 : 127;
        emax = hf ? 31 : 255;
        mask = (32'd1 << fb) - 1;
        s    = bits[fb + eb];
        ef   = int'((bits >> fb) & 32'(emax));
        fr   = bits & mask;
        m    = (ef != 0) ? 64'(fr | (mask + 1)) : 64'(fr);
        x    = ((ef != 0) ? ef : 1) - bias - fb;
    endfunction

    function automatic logic [31:0] round_and_pack(bit hf, bit s, logic [63:0] sig, int expo,
                                                   bit sticky, rmode_t mode);
        int fb;
        int bias;
        int emax;
        int p;
        int emin;
        int elsb;
        int shift;
        logic [63:0] q;
        logic [31:0] mask;
        bit half_bit;
        bit st;
        bit inc;
        bit to_inf;
        fb       = hf ? 10 : 23;
        bias     = hf ? 15 : 127;
        emax     = hf ? 31 : 255;
        mask     = (32'd1 << fb) - 1;
        emin     = 1 - bias - fb;
        st       = sticky;
        half_bit = 1'b0;
        if (sig == 0)
            return fp_encode(hf, s, 0, 0);
        p = 0;
        while ((sig >> p) > 1)
            p++;
        elsb = expo + p - fb;
        if (elsb < emin)
            elsb = emin;
        shift = elsb - expo;
        if (shift <= 0)
            q = sig << (-shift);
        else if (shift > 64)
        begin
            q  = 0;
            st = 1'b1;
        end
        else if (shift == 64)
        begin
            q        = 0;
            half_bit = sig[63];
            st       = st | (sig[62:0] != 0);
        end
        else
        begin
            q        = sig >> shift;
            half_bit = sig[shift - 1];
            st       = st | ((sig & ((64'd1 << (shift - 1)) - 1)) != 0);
        end
        case (mode)
            RM_RNE:  inc = half_bit && (st || q[0]);
            RM_RUP:  inc = !s && (half_bit || st);
            RM_RDN:  inc = s && (half_bit || st);
            default: inc = 1'b0;
        endcase
        if (inc)
            q++;
        if ((q >> (fb + 1)) != 0)
        begin
            q = q >> 1;
            elsb++;
        end
        if (q < (64'd1 << fb))
            return fp_encode(hf, s, 0, q[31:0] & mask);
        if (elsb + fb + bias >= emax)
        begin
            to_inf = (mode == RM_RNE) || (mode == RM_RUP && !s) || (mode == RM_RDN && s);
            if (to_inf)
                return fp_encode(hf, s, emax, 0);
            return fp_encode(hf, s, emax - 1, mask);
        end
        return fp_encode(hf, s, elsb + fb + bias, q[31:0] & mask);
    endfunction

    function automatic logic [31:0] sum_result(bit hf, logic [31:0] a, logic [31:0] b,
                                               bit subtract, rmode_t mode);
        bit sa;
        bit sb;
        bit sr;
        bit ts;
        int ea;
        int eb;
        int xa;
        int xb;
        int tx;
        int d;
        int emax;
        logic [31:0] fa;
        logic [31:0] fb;
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] tm;
        logic [63:0] sm;
        logic [63:0] r;
        emax = hf ? 31 : 255;
        fp_unpack(hf, a, sa, ea, fa, ma, xa);
        fp_unpack(hf, b, sb, eb, fb, mb, xb);
        if (subtract)
            sb = !sb;
        if ((ea == emax && fa != 0) || (eb == emax && fb != 0))
            return fp_qnan(hf);
        if (ea == emax && eb == emax)
            return (sa == sb) ? fp_encode(hf, sa, emax, 0) : fp_qnan(hf);
        if (ea == emax)
            return fp_encode(hf, sa, emax, 0);
        if (eb == emax)
            return fp_encode(hf, sb, emax, 0);
        ma = ma << 32;
        xa -= 32;
        mb = mb << 32;
        xb -= 32;
        if (xa < xb)
        begin
            tm = ma; tx = xa; ts = sa;
            ma = mb; xa = xb; sa = sb;
            mb = tm; xb = tx; sb = ts;
        end
        d = xa - xb;
        if (d >= 64)
            sm = (mb != 0) ? 64'd1 : 64'd0;
        else if (d > 0)
            sm = (mb >> d) | (((mb & ((64'd1 << d) - 1)) != 0) ? 64'd1 : 64'd0);
        else
            sm = mb;
        if (sa == sb)
        begin
            r  = ma + sm;
            sr = sa;
        end
        else if (ma >= sm)
        begin
            r  = ma - sm;
            sr = sa;
        end
        else
        begin
            r  = sm - ma;
            sr = sb;
        end
        if (r == 0)
        begin
            sr = (sa == sb) ? sa : (mode == RM_RDN);
            return fp_encode(hf, sr, 0, 0);
        end
        return round_and_pack(hf, sr, r, xa, 1'b0, mode);
    endfunction

    function automatic logic [31:0] product_quotient(bit hf, logic [31:0] a, logic [31:0] b,
                                                     bit divide, rmode_t mode);
        bit sa;
        bit sb;
        bit sr;
        bit ia;
        bit ib;
        bit za;
        bit zb;
        int ea;
        int eb;
        int xa;
        int xb;
        int emax;
        logic [31:0] fa;
        logic [31:0] fb;
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] hid;
        emax = hf ? 31 : 255;
        hid  = 64'd1 << (hf ? 10 : 23);
        fp_unpack(hf, a, sa, ea, fa, ma, xa);
        fp_unpack(hf, b, sb, eb, fb, mb, xb);
        sr = sa ^ sb;
        if ((ea == emax && fa != 0) || (eb == emax && fb != 0))
            return fp_qnan(hf);
        ia = (ea == emax);
        ib = (eb == emax);
        za = !ia && ma == 0;
        zb = !ib && mb == 0;
        if (!divide)
        begin
            if ((ia && zb) || (za && ib))
                return fp_qnan(hf);
            if (ia || ib)
                return fp_encode(hf, sr, emax, 0);
            if (za || zb)
                return fp_encode(hf, sr, 0, 0);
            return round_and_pack(hf, sr, ma * mb, xa + xb, 1'b0, mode);
        end
        if ((za && zb) || (ia && ib))
            return fp_qnan(hf);
        if (ia || zb)
            return fp_encode(hf, sr, emax, 0);
        if (za || ib)
            return fp_encode(hf, sr, 0, 0);
        while (ma < hid)
        begin
            ma = ma << 1;
            xa--;
        end
        while (mb < hid)
        begin
            mb = mb << 1;
            xb--;
        end
        return round_and_pack(hf, sr, (ma << 40) / mb, xa - 40 - xb,
                              ((ma << 40) % mb) != 0, mode);
    endfunction

    function automatic logic [31:0] fp_result(op_t op, logic [31:0] a, logic [31:0] b);
        bit hf;
        logic [31:0] keep;
        logic [31:0] r;
        hf   = !binary32_sel;
        keep = hf ? 32'h0000FFFF : 32'hFFFFFFFF;
        if (op == OP_ADD || op == OP_SUB)
            r = sum_result(hf, a & keep, b & keep, op == OP_SUB, round_sel);
        else
            r = product_quotient(hf, a & keep, b & keep, op == OP_DIV, round_sel);
        return r & keep;
    endfunction

    function automatic logic [31:0] random_operand(bit hf);
        logic [31:0] r;
        logic [31:0] v;
        int fb;
        int bias;
        int emax;
        fb   = hf ? 10 : 23;
        bias = hf ? 15 : 127;
        emax = hf ? 31 : 255;
        r    = $urandom();
        case ($urandom_range(9))
            0:
            begin
                case ($urandom_range(5))
                    0: v = 0;
                    1: v = fp_encode(hf, 0, emax, 0);
                    2: v = fp_encode(hf, 0, emax, $urandom_range((1 << fb) - 1, 1));
                    3: v = fp_encode(hf, 0, emax - 1, (32'd1 << fb) - 1);
                    4: v = 1;
                    default: v = fp_encode(hf, 0, bias, 0);
                endcase
                v = v | fp_encode(hf, $urandom_range(1), 0, 0);
            end
            1: v = fp_encode(hf, r[31], 0, r & ((32'd1 << fb) - 1));
            2, 3: v = fp_encode(hf, r[31], bias + $urandom_range(6) - 3, r & ((32'd1 << fb) - 1));
            default: v = r;
        endcase
        if (hf)
            return {r[31:16], v[15:0]};
        return v;
    endfunction

    task automatic report_mismatch(logic [31:0] want, logic [31:0] got);
        $display("mismatch at cycle %0d: result_bits expected %h got %h", cycles, want, got);
        errors++;
    endtask

    task automatic send_request(op_t op, logic [31:0] a, logic [31:0] b, bit known,
                                logic [31:0] want);
        while (!calm && $urandom_range(99) < 13)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= op;
        req_ch.operand_a <= a;
        req_ch.operand_b <= b;
        do
            @(posedge clk);
        while (!req_ch.ready);
        expected_results.push_back(known ? want : fp_result(op, a, b));
    endtask

    task automatic write_register(logic idx, logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_PRECISION)
            binary32_sel = value[0];
        else
            round_sel = rmode_t'(value);
        @(posedge clk);
    endtask

    task automatic drain();
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_burst(int count);
        logic [31:0] a;
        logic [31:0] b;
        op_t op;
        for (int i = 0; i < count; i++)
        begin
            op = op_t'($urandom_range(3));
            a  = random_operand(!binary32_sel);
            b  = random_operand(!binary32_sel);
            if ($urandom_range(7) == 0)
            begin
                b = a ^ 32'($urandom_range(3));
                b[binary32_sel ? 31 : 15] = $urandom_range(1);
                op = OP_SUB;
            end
            send_request(op, a, b, 1'b0, 32'h0);
        end
        req_ch.valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("unexpected result transaction at cycle %0d: %h", cycles,
                         res_ch.result_bits);
                errors++;
            end
            else
            begin
                if (res_ch.result_bits !== expected_results[0])
                    report_mismatch(expected_results[0], res_ch.result_bits);
                void'(expected_results.pop_front());
            end
        end
        res_ch.ready <= calm || ($urandom_range(99) >= 13);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = CFG_PRECISION;
        cfg_wdata        = '0;
        req_ch.valid     = 1'b0;
        req_ch.req_type  = OP_ADD;
        req_ch.operand_a = '0;
        req_ch.operand_b = '0;
        res_ch.ready     = 1'b0;
        binary32_sel     = 1'b1;
        round_sel        = RM_RTZ;
        calm             = 1'b0;
        errors           = 0;
        cycles           = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_request(directed[i].op, directed[i].a, directed[i].b,
                         directed[i].known, directed[i].want);
        random_burst(RANDOM_PER_PHASE - 40);
        drain();

        for (int ph = 1; ph < 9; ph++)
        begin
            calm = (ph == 4);
            write_register(CFG_PRECISION, CFG_W'(ph >= 5 && ph < 8 ? 0 : (ph == 8 ? 0 : 1)));
            write_register(CFG_ROUNDING, CFG_W'(ph % 4));
            random_burst(RANDOM_PER_PHASE);
            drain();
        end

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
src/fpasmd_pkg.sv
src/fpasmd_if.sv
src/fp_add_sub_mul_div.sv
tb/tb_top.sv
